// ===== src/palette_nearest_color_remap_defines.svh =====
// Assertion macros shared by the palette remap block
`ifndef PALETTE_NEAREST_COLOR_REMAP_DEFINES_SVH
`define PALETTE_NEAREST_COLOR_REMAP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PNCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PNCR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pncr_pkg.sv =====
// Types, codes and constants shared by the palette remap block
`default_nettype none

package pncr_pkg;

	localparam int DEPTH_DEFAULT = 256;
	localparam int DIST_W = 18;
	localparam logic [DIST_W-1:0] START_DIST = DIST_W'(255 * 255 * 3);

	localparam logic [1:0] REG_OFFSET   = 2'd0;
	localparam logic [1:0] REG_ENTRIES  = 2'd1;
	localparam logic [1:0] REG_WRITABLE = 2'd2;

	typedef enum logic [1:0] {
		ACT_LOAD_PAL   = 2'd0,
		ACT_LOAD_REMAP = 2'd1,
		ACT_STREAM     = 2'd2,
		ACT_READ_PAL   = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOADP,
		ST_LOADR,
		ST_READ,
		ST_RDATA,
		ST_REDUCE,
		ST_DECIDE,
		ST_SEARCH,
		ST_UPDATE,
		ST_RESP
	} state_t;

	typedef enum logic [2:0] {
		RES_HOLD,
		RES_ZERO,
		RES_REMAP,
		RES_READ,
		RES_WRITABLE,
		RES_SEARCH
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     wr_pal_item;
		logic     wr_remap_item;
		logic     rd_pal_item;
		logic     reduce;
		logic     wr_pal_stream;
		logic     search_init;
		logic     search;
		logic     update;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic reduced;
		logic writable;
		logic search_done;
	} status_t;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

`default_nettype wire

// ===== src/pncr_datapath.sv =====
// Datapath: configuration registers, palette and remap memories, nearest search pipeline
`default_nettype none

module pncr_datapath import pncr_pkg::*; #(
	parameter int PALETTE_DEPTH = DEPTH_DEFAULT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write,
	input  wire logic [1:0] cfg_index,
	input  wire logic [8:0] cfg_data,
	input  wire logic [7:0] index,
	input  wire logic [7:0] remap_value,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	input  wire cmd_t       cmd,
	output status_t         status,
	output logic [7:0]      mapped_index,
	output logic            remap_changed,
	output logic [7:0]      out_red,
	output logic [7:0]      out_green,
	output logic [7:0]      out_blue
);

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_DEPTH - 1);

	logic [7:0] offset_q;
	logic [8:0] entries_q;
	logic [8:0] writable_q;

	logic [7:0] idx_q, rv_q, red_q, green_q, blue_q;
	logic [7:0] off_red_q;

	logic [7:0]  remap_mem [256];
	logic [7:0]  remap_q;
	logic [23:0] pal_mem [PALETTE_DEPTH];
	logic [23:0] pal_rdata_q;

	logic [8:0]          cnt_q;
	logic [AW-1:0]       addr_q;
	logic                v_s1, v_s2;
	logic [AW-1:0]       a_s1, a_s2;
	logic [15:0]         sq_r_s2, sq_g_s2, sq_b_s2;
	logic [DIST_W-1:0]   best_q;
	logic [AW-1:0]       pick_q;

	logic [7:0] mapped_q, red_out_q, green_out_q, blue_out_q;
	logic       changed_q;

	logic [8:0]        win_n;
	logic              idx_ok, cur_ok, stream_hit, changed, issue;
	logic [8:0]        cur9, off9, rel;
	logic [AW-1:0]     off_mod, addr_next;
	logic              pal_we, pal_re, remap_we;
	logic [AW-1:0]     pal_waddr, pal_raddr;
	logic [7:0]        remap_wdata;
	logic [7:0]        dr, dg, db;
	logic [DIST_W-1:0] dist_sum;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= '0;
			entries_q  <= 9'd256;
			writable_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_OFFSET:   offset_q   <= cfg_data[7:0];
				REG_ENTRIES:  entries_q  <= cfg_data;
				REG_WRITABLE: writable_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign win_n = (entries_q > DEPTH9) ? DEPTH9 : entries_q;

	// Capture the request and step the window offset down below the depth
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q     <= index;
			rv_q      <= remap_value;
			red_q     <= red;
			green_q   <= green;
			blue_q    <= blue;
			off_red_q <= offset_q;
		end else if (cmd.reduce && !status.reduced) begin
			off_red_q <= 8'({1'b0, off_red_q} - DEPTH9);
		end
	end

	assign off_mod = off_red_q[AW-1:0];

	always_comb begin
		idx_ok     = {1'b0, idx_q} < DEPTH9;
		cur9       = {1'b0, remap_q};
		off9       = {1'b0, off_red_q};
		cur_ok     = cur9 < DEPTH9;
		rel        = (cur9 >= off9) ? (cur9 - off9) : (cur9 + DEPTH9 - off9);
		stream_hit = cur_ok && (rel < win_n);
		changed    = 8'(pick_q) != remap_q;
		issue      = cmd.search && (cnt_q < win_n);
		addr_next  = (addr_q == LAST_ADDR) ? '0 : AW'(addr_q + 1'b1);

		status.reduced     = off9 < DEPTH9;
		status.writable    = {1'b0, idx_q} < writable_q;
		status.search_done = (cnt_q >= win_n) && !v_s1 && !v_s2;

		pal_we    = (cmd.wr_pal_item && idx_ok) || (cmd.wr_pal_stream && stream_hit);
		pal_waddr = cmd.wr_pal_item ? idx_q[AW-1:0] : remap_q[AW-1:0];
		pal_re    = cmd.rd_pal_item || issue;
		pal_raddr = issue ? addr_q : idx_q[AW-1:0];

		remap_we    = cmd.wr_remap_item || (cmd.update && changed);
		remap_wdata = cmd.wr_remap_item ? rv_q : 8'(pick_q);
	end

	// Remap memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (remap_we)
			remap_mem[idx_q] <= remap_wdata;
		if (cmd.reduce)
			remap_q <= remap_mem[idx_q];
	end

	// Palette memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (pal_we)
			pal_mem[pal_waddr] <= {red_q, green_q, blue_q};
		if (pal_re)
			pal_rdata_q <= pal_mem[pal_raddr];
	end

	// Search pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		dr       = abs_diff(red_q,   pal_rdata_q[23:16]);
		dg       = abs_diff(green_q, pal_rdata_q[15:8]);
		db       = abs_diff(blue_q,  pal_rdata_q[7:0]);
		dist_sum = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);
	end

	always_ff @(posedge clk) begin
		if (cmd.search_init) begin
			cnt_q  <= '0;
			addr_q <= off_mod;
			best_q <= START_DIST;
			pick_q <= off_mod;
		end else begin
			if (issue) begin
				cnt_q  <= cnt_q + 9'd1;
				addr_q <= addr_next;
				a_s1   <= addr_q;
			end
			// Strictly smaller only: ties keep the earlier entry
			if (v_s2 && (dist_sum < best_q)) begin
				best_q <= dist_sum;
				pick_q <= a_s2;
			end
		end
		if (v_s1) begin
			sq_r_s2 <= 16'(dr) * 16'(dr);
			sq_g_s2 <= 16'(dg) * 16'(dg);
			sq_b_s2 <= 16'(db) * 16'(db);
			a_s2    <= a_s1;
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		case (cmd.res_sel)
			RES_ZERO: begin
				mapped_q    <= '0;
				changed_q   <= 1'b0;
				red_out_q   <= '0;
				green_out_q <= '0;
				blue_out_q  <= '0;
			end
			RES_REMAP: begin
				mapped_q    <= rv_q;
				changed_q   <= 1'b0;
				red_out_q   <= '0;
				green_out_q <= '0;
				blue_out_q  <= '0;
			end
			RES_READ: begin
				mapped_q    <= '0;
				changed_q   <= 1'b0;
				red_out_q   <= idx_ok ? pal_rdata_q[23:16] : 8'd0;
				green_out_q <= idx_ok ? pal_rdata_q[15:8]  : 8'd0;
				blue_out_q  <= idx_ok ? pal_rdata_q[7:0]   : 8'd0;
			end
			RES_WRITABLE: begin
				mapped_q    <= remap_q;
				changed_q   <= 1'b0;
				red_out_q   <= '0;
				green_out_q <= '0;
				blue_out_q  <= '0;
			end
			RES_SEARCH: begin
				mapped_q    <= 8'(pick_q);
				changed_q   <= changed;
				red_out_q   <= '0;
				green_out_q <= '0;
				blue_out_q  <= '0;
			end
			default: ;
		endcase
	end

	assign mapped_index  = mapped_q;
	assign remap_changed = changed_q;
	assign out_red       = red_out_q;
	assign out_green     = green_out_q;
	assign out_blue      = blue_out_q;

endmodule

`default_nettype wire

// ===== src/pncr_ctrl.sv =====
// Controller state machine: sequences each request through the datapath
`default_nettype none

module pncr_ctrl import pncr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] action,
	input  wire status_t    status,
	output cmd_t            cmd,
	output logic            busy,
	output logic            done
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.res_sel = RES_HOLD;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					case (action_t'(action))
						ACT_LOAD_PAL:   state_d = ST_LOADP;
						ACT_LOAD_REMAP: state_d = ST_LOADR;
						ACT_STREAM:     state_d = ST_REDUCE;
						ACT_READ_PAL:   state_d = ST_READ;
						default:        state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOADP: begin
				cmd.wr_pal_item = 1'b1;
				cmd.res_sel     = RES_ZERO;
				state_d         = ST_RESP;
			end
			ST_LOADR: begin
				cmd.wr_remap_item = 1'b1;
				cmd.res_sel       = RES_REMAP;
				state_d           = ST_RESP;
			end
			ST_READ: begin
				cmd.rd_pal_item = 1'b1;
				state_d         = ST_RDATA;
			end
			ST_RDATA: begin
				cmd.res_sel = RES_READ;
				state_d     = ST_RESP;
			end
			ST_REDUCE: begin
				// remap entry is read here too; hold until the offset is in range
				cmd.reduce = 1'b1;
				if (status.reduced)
					state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (status.writable) begin
					cmd.wr_pal_stream = 1'b1;
					cmd.res_sel       = RES_WRITABLE;
					state_d           = ST_RESP;
				end else begin
					cmd.search_init = 1'b1;
					state_d         = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
				if (status.search_done)
					state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update  = 1'b1;
				cmd.res_sel = RES_SEARCH;
				state_d     = ST_RESP;
			end
			ST_RESP: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== src/palette_nearest_color_remap.sv =====
// Top level of the palette nearest-colour remap block
//
// Channel   Ports                                              Handshake
// request   action index remap_value red green blue last_color  start high, busy low
// result    mapped_index remap_changed out_red out_green out_blue  done, one cycle
// config    cfg_index cfg_data                                 cfg_write, no wait
//
// One request at a time; done is raised in ST_RESP. Stream colours: the window start
// steps down by PALETTE_DEPTH in ST_REDUCE until it is in range, then a writable slot
// is written, or ST_SEARCH runs a search over the n window entries, one palette
// memory read per cycle through a three-stage distance pipeline.
// Reset clears control state, config registers and valid bits; memory is undefined.
// The receiver cannot stall: each result is shown for the one cycle that done is high.
// last_color has no effect, as palette writes take effect at once.
`default_nettype none
`include "palette_nearest_color_remap_defines.svh"

module palette_nearest_color_remap import pncr_pkg::*; #(
	parameter int PALETTE_DEPTH = DEPTH_DEFAULT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] action,
	input  wire logic [7:0] index,
	input  wire logic [7:0] remap_value,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	input  wire logic       last_color,
	output logic            done,
	output logic [7:0]      mapped_index,
	output logic            remap_changed,
	output logic [7:0]      out_red,
	output logic [7:0]      out_green,
	output logic [7:0]      out_blue,
	input  wire logic       cfg_write,
	input  wire logic [1:0] cfg_index,
	input  wire logic [8:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	pncr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pncr_datapath #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.index         (index),
		.remap_value   (remap_value),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.cmd           (cmd),
		.status        (status),
		.mapped_index  (mapped_index),
		.remap_changed (remap_changed),
		.out_red       (out_red),
		.out_green     (out_green),
		.out_blue      (out_blue)
	);

	`PNCR_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted request did not raise busy")
	`PNCR_ASSERT_IMP(a_done_busy, clk, arst_n, done, busy, "result strobe outside a request")
	`PNCR_ASSERT_NXT(a_done_single, clk, arst_n, done, !done && !busy, "result strobe longer than one cycle")

endmodule

`default_nettype wire

// ===== sim/palette_remap_checker.sv =====
// Checker that predicts and compares every result of the palette remap block
module palette_remap_checker import pncr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       busy,
	input  wire logic [1:0] action,
	input  wire logic [7:0] index,
	input  wire logic [7:0] remap_value,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	input  wire logic       done,
	input  wire logic [7:0] mapped_index,
	input  wire logic       remap_changed,
	input  wire logic [7:0] out_red,
	input  wire logic [7:0] out_green,
	input  wire logic [7:0] out_blue,
	input  wire logic       cfg_write,
	input  wire logic [1:0] cfg_index,
	input  wire logic [8:0] cfg_data,
	output int              fails,
	output int              outstanding
);

	localparam int unsigned FAR_DIST = 255 * 255 * 3;

	typedef struct packed {
		logic [7:0] mapped;
		logic       changed;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} answer_t;

	logic [23:0] palette [256];
	logic [7:0]  slot_map [256];
	logic [7:0]  win_offset = '0;
	logic [8:0]  win_entries = 9'd256;
	logic [8:0]  writable = '0;
	answer_t     answers_due [$];
	int          fail_total = 0;
	int          due_count = 0;

	assign fails = fail_total;
	assign outstanding = due_count;

	function automatic int unsigned sq_gap(logic [7:0] a, logic [7:0] b);
		int unsigned d;
		d = (a > b) ? a - b : b - a;
		return d * d;
	endfunction

	// Apply one request to the shadow stores and return its result
	function automatic answer_t remap_outcome(action_t act, logic [7:0] idx, logic [7:0] rv,
			logic [7:0] r, logic [7:0] g, logic [7:0] b);
		answer_t     ans;
		int unsigned span;
		int unsigned best;
		int unsigned gap_sum;
		int unsigned pick;
		int unsigned j;
		logic [7:0]  addr;
		logic [7:0]  cur;
		logic [7:0]  rel;
		logic [23:0] e;
		ans = '0;
		span = (win_entries > 9'd256) ? 256 : win_entries;
		case (act)
			ACT_LOAD_PAL: begin
				palette[idx] = {r, g, b};
			end
			ACT_LOAD_REMAP: begin
				slot_map[idx] = rv;
				ans.mapped = rv;
			end
			ACT_STREAM: begin
				cur = slot_map[idx];
				if (idx < writable) begin
					// write only where the target lies inside the window
					rel = cur - win_offset;
					if (rel < span)
						palette[cur] = {r, g, b};
					ans.mapped = cur;
				end else begin
					best = FAR_DIST;
					pick = 0;
					for (j = 0; j < span; j++) begin
						addr = win_offset + j[7:0];
						e = palette[addr];
						gap_sum = sq_gap(r, e[23:16]) + sq_gap(g, e[15:8]) + sq_gap(b, e[7:0]);
						if (gap_sum < best) begin
							best = gap_sum;
							pick = j;
						end
					end
					addr = win_offset + pick[7:0];
					ans.mapped = addr;
					if (addr != cur) begin
						slot_map[idx] = addr;
						ans.changed = 1'b1;
					end
				end
			end
			default: begin
				{ans.r, ans.g, ans.b} = palette[idx];
			end
		endcase
		return ans;
	endfunction

	task automatic log_failure(string what);
		fail_total++;
		if (fail_total <= 10)
			$display("%0t: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		answer_t got;
		if (!arst_n) begin
			win_offset = '0;
			win_entries = 9'd256;
			writable = '0;
			answers_due.delete();
			due_count <= 0;
		end else begin
			// retire the result before taking a new request in the same cycle
			if (done) begin
				got = {mapped_index, remap_changed, out_red, out_green, out_blue};
				if (answers_due.size() == 0) begin
					log_failure($sformatf("result with no request pending: map %0d chg %0b rgb %02x%02x%02x",
						got.mapped, got.changed, got.r, got.g, got.b));
				end else begin
					want = answers_due.pop_front();
					if (got !== want)
						log_failure($sformatf(
							"mismatch: expected map %0d chg %0b rgb %02x%02x%02x, got map %0d chg %0b rgb %02x%02x%02x",
							want.mapped, want.changed, want.r, want.g, want.b,
							got.mapped, got.changed, got.r, got.g, got.b));
				end
			end
			if (start && !busy)
				answers_due.push_back(remap_outcome(action_t'(action), index, remap_value,
					red, green, blue));
			if (cfg_write) begin
				case (cfg_index)
					REG_OFFSET: begin
						win_offset = cfg_data[7:0];
					end
					REG_ENTRIES: begin
						win_entries = cfg_data;
					end
					REG_WRITABLE: begin
						writable = cfg_data;
					end
					default: begin
					end
				endcase
			end
			due_count <= answers_due.size();
		end
	end

endmodule

// ===== sim/palette_nearest_color_remap_tb.sv =====
// Stimulus and verdict for the palette nearest-colour remap block
module palette_nearest_color_remap_tb;
	import pncr_pkg::*;

	localparam int RUN_LIMIT = 2_000_000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	action_t    action = ACT_LOAD_PAL;
	logic [7:0] index = '0;
	logic [7:0] remap_value = '0;
	logic [7:0] red = '0;
	logic [7:0] green = '0;
	logic [7:0] blue = '0;
	logic       last_color = 1'b0;
	logic       cfg_write = 1'b0;
	logic [1:0] cfg_index = REG_OFFSET;
	logic [8:0] cfg_data = '0;

	wire logic       busy;
	wire logic       done;
	wire logic [7:0] mapped_index;
	wire logic       remap_changed;
	wire logic [7:0] out_red;
	wire logic [7:0] out_green;
	wire logic [7:0] out_blue;

	int         fails;
	int         outstanding;
	int         cycles = 0;
	bit         quiet = 1'b0;
	logic [7:0] win_off = '0;
	logic [8:0] win_ent = 9'd256;
	logic [8:0] win_wr = '0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	palette_nearest_color_remap dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.index(index), .remap_value(remap_value), .red(red), .green(green), .blue(blue),
		.last_color(last_color), .done(done), .mapped_index(mapped_index),
		.remap_changed(remap_changed), .out_red(out_red), .out_green(out_green),
		.out_blue(out_blue), .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	palette_remap_checker u_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.index(index), .remap_value(remap_value), .red(red), .green(green), .blue(blue),
		.done(done), .mapped_index(mapped_index), .remap_changed(remap_changed),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .outstanding(outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Colour component biased towards the extremes so that ties and exact hits occur
	function automatic logic [7:0] shade();
		case ($urandom_range(9))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hFF;
			end
			2: begin
				return 8'h80;
			end
			default: begin
				return 8'($urandom);
			end
		endcase
	endfunction

	// Present one request and hold it until the block takes it
	task automatic send_request(action_t act, logic [7:0] idx, logic [7:0] rv,
			logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
		if (!quiet) begin
			while ($urandom_range(99) < 12) begin
				start <= 1'b0;
				index <= 8'($urandom);
				red <= 8'($urandom);
				@(posedge clk);
			end
		end
		start <= 1'b1;
		action <= act;
		index <= idx;
		remap_value <= rv;
		red <= r;
		green <= g;
		blue <= b;
		last_color <= last;
		do @(posedge clk); while (busy);
	endtask

	task automatic settle(int unsigned tail);
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
		repeat (tail) @(posedge clk);
	endtask

	task automatic set_window(logic [7:0] off, logic [8:0] ent, logic [8:0] wr);
		settle(4);
		cfg_write <= 1'b1;
		cfg_index <= REG_OFFSET;
		cfg_data <= {1'b0, off};
		@(posedge clk);
		cfg_index <= REG_ENTRIES;
		cfg_data <= ent;
		@(posedge clk);
		cfg_index <= REG_WRITABLE;
		cfg_data <= wr;
		@(posedge clk);
		cfg_write <= 1'b0;
		win_off = off;
		win_ent = ent;
		win_wr = wr;
	endtask

	task automatic random_item();
		int unsigned roll;
		logic [7:0]  slot;
		logic [7:0]  target;
		roll = $urandom_range(99);
		slot = 8'($urandom);
		// aim half the remap loads inside the current window
		if (win_ent >= 9'd256 || $urandom_range(1))
			target = 8'($urandom);
		else
			target = win_off + 8'($urandom_range(win_ent - 1));
		// hug the writable boundary for part of the stream requests
		if (roll >= 45 && roll < 60 && win_wr != 0 && win_wr < 9'd256)
			slot = 8'(win_wr - $urandom_range(1));
		if (roll < 25)
			send_request(ACT_LOAD_PAL, slot, 8'($urandom), shade(), shade(), shade(),
				1'($urandom));
		else if (roll < 45)
			send_request(ACT_LOAD_REMAP, slot, target, 8'($urandom), 8'($urandom),
				8'($urandom), 1'($urandom));
		else if (roll < 85)
			send_request(ACT_STREAM, slot, 8'($urandom), shade(), shade(), shade(),
				1'($urandom));
		else
			send_request(ACT_READ_PAL, slot, 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom), 1'($urandom));
	endtask

	initial begin
		logic [7:0] off;
		logic [8:0] ent;
		logic [8:0] wr;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill both stores so that no read ever touches an unwritten entry
		for (int i = 0; i < 256; i++) begin
			send_request(ACT_LOAD_PAL, 8'(i), 8'($urandom), shade(), shade(), shade(), 1'b0);
			send_request(ACT_LOAD_REMAP, 8'(i), 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom), 1'b1);
		end

		// full window, nothing writable
		send_request(ACT_LOAD_PAL, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0);
		send_request(ACT_LOAD_PAL, 8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_request(ACT_READ_PAL, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0);
		send_request(ACT_READ_PAL, 8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_request(ACT_LOAD_REMAP, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0);
		send_request(ACT_LOAD_REMAP, 8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_request(ACT_STREAM, 8'd255, 8'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_request(ACT_STREAM, 8'd0, 8'd255, 8'h00, 8'h00, 8'h00, 1'b0);

		// window wrapping past the top, a few writable slots
		set_window(8'd250, 9'd10, 9'd4);
		send_request(ACT_LOAD_REMAP, 8'd1, 8'd252, 8'h00, 8'h00, 8'h00, 1'b0);
		send_request(ACT_LOAD_REMAP, 8'd2, 8'd100, 8'h00, 8'h00, 8'h00, 1'b0);
		send_request(ACT_LOAD_REMAP, 8'd3, 8'd3, 8'h00, 8'h00, 8'h00, 1'b0);
		send_request(ACT_STREAM, 8'd1, 8'd0, 8'h12, 8'h34, 8'h56, 1'b0);
		send_request(ACT_STREAM, 8'd2, 8'd0, 8'hA5, 8'h5A, 8'hC3, 1'b0);
		send_request(ACT_STREAM, 8'd3, 8'd0, 8'h12, 8'h34, 8'h56, 1'b0);
		send_request(ACT_STREAM, 8'd4, 8'd0, 8'h12, 8'h34, 8'h56, 1'b1);
		send_request(ACT_READ_PAL, 8'd252, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0);
		send_request(ACT_READ_PAL, 8'd100, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0);
		send_request(ACT_READ_PAL, 8'd3, 8'd0, 8'h00, 8'h00, 8'h00, 1'b1);

		// one-entry window at the top where no entry beats the start distance
		set_window(8'd255, 9'd1, 9'd0);
		send_request(ACT_LOAD_PAL, 8'd255, 8'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_request(ACT_STREAM, 8'd5, 8'd0, 8'h00, 8'h00, 8'h00, 1'b1);

		// every slot writable
		set_window(8'd0, 9'd256, 9'd256);
		send_request(ACT_STREAM, 8'd255, 8'd0, 8'h7F, 8'h80, 8'h01, 1'b1);
		send_request(ACT_STREAM, 8'd0, 8'd0, 8'hFE, 8'h01, 8'h80, 1'b0);
		send_request(ACT_READ_PAL, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0);

		// random phases; mostly narrow windows, two wide ones
		for (int p = 0; p < 12; p++) begin
			case ($urandom_range(3))
				0: begin
					off = 8'd0;
				end
				1: begin
					off = 8'd255;
				end
				default: begin
					off = 8'($urandom);
				end
			endcase
			if (p == 3)
				ent = 9'd256;
			else if (p == 8)
				ent = 9'($urandom_range(129, 256));
			else
				ent = 9'($urandom_range(1, 32));
			case ($urandom_range(3))
				0: begin
					wr = 9'd0;
				end
				1: begin
					wr = 9'd256;
				end
				default: begin
					wr = 9'($urandom_range(1, 255));
				end
			endcase
			set_window(off, ent, wr);
			quiet = (p == 5);
			repeat (100) random_item();
		end
		quiet = 1'b0;

		settle(300);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
